// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the set intersection block.
// Needs nothing else; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/sid_pkg.sv =====
// Package of the set intersection block: sizes, operation codes, state type,
// and the command and status structs between controller and datapath.
package sid_pkg;

	localparam int DEPTH     = 32;
	localparam int KEY_WIDTH = 64;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OP_W      = 2;

	localparam logic [OP_W-1:0] OP_ADD_FIRST  = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD_SECOND = 2'd1;
	localparam logic [OP_W-1:0] OP_RUN        = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CAND_RD,
		ST_CAND_LD,
		ST_DUP_RD,
		ST_DUP_CMP,
		ST_SEC_RD,
		ST_SEC_CMP,
		ST_PUSH,
		ST_NEXT,
		ST_FINISH
	} sid_state_t;

	typedef struct packed {
		logic load_first;
		logic load_second;
		logic sel_j;
		logic latch_cand;
		logic i_clr;
		logic i_inc;
		logic j_clr;
		logic j_inc;
		logic push_pend;
		logic emit_final;
	} sid_cmd_t;

	typedef struct packed {
		logic first_empty;
		logic i_last;
		logic j_at_i;
		logic j_at_sc;
		logic dup_hit;
		logic sec_hit;
		logic pend_vld;
		logic slot_free;
	} sid_status_t;

endpackage

// ===== rtl/set_intersection_distinct.sv =====
// Top level of the set intersection block: controller plus datapath.
// Depends on sid_pkg, sid_ctrl, sid_dp and assert_macros.svh.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------
//   input   | in_valid, in_stall | operation, key
//   output  | out_valid,out_stall| common_key, found, last, overflow
//
// Add requests are accepted in the idle state; back-to-back loads are accepted.
// A compute request walks the stores through one read port each: per first-list
// entry i, up to i duplicate compares plus up to second-count compares, each
// compare being a read state followed by a compare state.
// in_stall stays high for the whole compute; a stalled output only extends it.
// Reset clears the counts and flags; the key stores need no clearing.
module set_intersection_distinct (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sid_pkg::OP_W-1:0]      operation,
	input  logic [sid_pkg::KEY_WIDTH-1:0] key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sid_pkg::KEY_WIDTH-1:0] common_key,
	output logic                          found,
	output logic                          last,
	output logic                          overflow
);
	import sid_pkg::*;

	`include "assert_macros.svh"

	sid_cmd_t    cmd;
	sid_status_t sts;

	sid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_stall  (in_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sid_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.key        (key),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.common_key (common_key),
		.found      (found),
		.last       (last),
		.overflow   (overflow)
	);

	`SID_ASSERT_NEXT(a_final_is_last, clk, arst_n, cmd.emit_final, out_valid && last)
	`SID_ASSERT_NEXT(a_final_frees_input, clk, arst_n, cmd.emit_final, !in_stall)
	`SID_ASSERT_NEXT(a_run_holds_input, clk, arst_n, in_valid && !in_stall && operation == OP_RUN, in_stall)
	`SID_ASSERT_NOW(a_push_needs_slot, clk, arst_n, cmd.push_pend && sts.pend_vld, !out_valid || !out_stall)

endmodule

// ===== rtl/sid_ctrl.sv =====
// Controller of the set intersection block: the sequencing state machine.
// Depends on sid_pkg for the state type and the command and status structs.
module sid_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [sid_pkg::OP_W-1:0] operation,
	output logic                     in_stall,
	input  sid_pkg::sid_status_t     sts,
	output sid_pkg::sid_cmd_t        cmd
);
	import sid_pkg::*;

	sid_state_t state_q;
	sid_state_t state_nxt;
	logic       run_req;

	assign run_req = in_valid && (operation == OP_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (run_req) begin
					state_nxt = sts.first_empty ? ST_FINISH : ST_CAND_RD;
				end
			end
			ST_CAND_RD: state_nxt = ST_CAND_LD;
			ST_CAND_LD: state_nxt = ST_DUP_RD;
			ST_DUP_RD:  state_nxt = sts.j_at_i ? ST_SEC_RD : ST_DUP_CMP;
			ST_DUP_CMP: state_nxt = sts.dup_hit ? ST_NEXT : ST_DUP_RD;
			ST_SEC_RD:  state_nxt = sts.j_at_sc ? ST_NEXT : ST_SEC_CMP;
			ST_SEC_CMP: state_nxt = sts.sec_hit ? ST_PUSH : ST_SEC_RD;
			ST_PUSH: begin
				if (!sts.pend_vld || sts.slot_free) begin
					state_nxt = ST_NEXT;
				end
			end
			ST_NEXT:    state_nxt = sts.i_last ? ST_FINISH : ST_CAND_RD;
			ST_FINISH: begin
				if (sts.slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default:    state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall        = 1'b0;
				cmd.load_first  = in_valid && (operation == OP_ADD_FIRST);
				cmd.load_second = in_valid && (operation == OP_ADD_SECOND);
				cmd.i_clr       = run_req;
			end
			ST_CAND_LD: begin
				cmd.latch_cand = 1'b1;
				cmd.j_clr      = 1'b1;
			end
			ST_DUP_RD: begin
				cmd.sel_j = 1'b1;
				cmd.j_clr = sts.j_at_i;
			end
			ST_DUP_CMP: begin
				cmd.j_inc = !sts.dup_hit;
			end
			ST_SEC_CMP: begin
				cmd.j_inc = !sts.sec_hit;
			end
			ST_PUSH: begin
				cmd.push_pend = !sts.pend_vld || sts.slot_free;
			end
			ST_NEXT: begin
				cmd.i_inc = 1'b1;
			end
			ST_FINISH: begin
				cmd.emit_final = sts.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/sid_dp.sv =====
// Datapath of the set intersection block: both key stores, counters,
// candidate and pending registers, and the result register.
// Depends on sid_pkg; driven by sid_ctrl through the command struct.
module sid_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sid_pkg::KEY_WIDTH-1:0] key,
	input  sid_pkg::sid_cmd_t             cmd,
	output sid_pkg::sid_status_t          sts,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sid_pkg::KEY_WIDTH-1:0] common_key,
	output logic                          found,
	output logic                          last,
	output logic                          overflow
);
	import sid_pkg::*;

	logic [KEY_WIDTH-1:0] first_mem  [DEPTH];
	logic [KEY_WIDTH-1:0] second_mem [DEPTH];
	logic [KEY_WIDTH-1:0] f_rdata_q;
	logic [KEY_WIDTH-1:0] s_rdata_q;
	logic [CNT_W-1:0]     fc_q;
	logic [CNT_W-1:0]     sc_q;
	logic [CNT_W-1:0]     i_q;
	logic [CNT_W-1:0]     j_q;
	logic [CNT_W-1:0]     f_addr;
	logic                 ovf_q;
	logic                 fc_full;
	logic                 sc_full;
	logic [KEY_WIDTH-1:0] cand_q;
	logic [KEY_WIDTH-1:0] pend_q;
	logic                 pend_vld_q;
	logic                 out_vld_q;
	logic [KEY_WIDTH-1:0] out_key_q;
	logic                 out_found_q;
	logic                 out_last_q;
	logic                 out_ovf_q;
	logic                 slot_free;
	logic                 out_load;

	assign fc_full   = (fc_q == CNT_W'(DEPTH));
	assign sc_full   = (sc_q == CNT_W'(DEPTH));
	assign f_addr    = cmd.sel_j ? j_q : i_q;
	assign slot_free = !out_vld_q || !out_stall;
	assign out_load  = cmd.emit_final || (cmd.push_pend && pend_vld_q);

	always_ff @(posedge clk) begin
		if (cmd.load_first && !fc_full) begin
			first_mem[fc_q[IDX_W-1:0]] <= key;
		end
		f_rdata_q <= first_mem[f_addr[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_second && !sc_full) begin
			second_mem[sc_q[IDX_W-1:0]] <= key;
		end
		s_rdata_q <= second_mem[j_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q  <= '0;
			sc_q  <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.emit_final) begin
			fc_q  <= '0;
			sc_q  <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.load_first) begin
				if (fc_full) begin
					ovf_q <= 1'b1;
				end else begin
					fc_q <= fc_q + 1'b1;
				end
			end
			if (cmd.load_second) begin
				if (sc_full) begin
					ovf_q <= 1'b1;
				end else begin
					sc_q <= sc_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (cmd.i_clr) begin
				i_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_cand) begin
			cand_q <= f_rdata_q;
		end
		if (cmd.push_pend) begin
			pend_q <= cand_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (cmd.emit_final) begin
			pend_vld_q <= 1'b0;
		end else if (cmd.push_pend) begin
			pend_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_key_q   <= pend_vld_q ? pend_q : '0;
			out_found_q <= pend_vld_q;
			out_last_q  <= cmd.emit_final;
			out_ovf_q   <= ovf_q;
		end
	end

	assign sts.first_empty = (fc_q == '0);
	assign sts.i_last      = (CNT_W'(i_q + 1'b1) == fc_q);
	assign sts.j_at_i      = (j_q == i_q);
	assign sts.j_at_sc     = (j_q == sc_q);
	assign sts.dup_hit     = (f_rdata_q == cand_q);
	assign sts.sec_hit     = (s_rdata_q == cand_q);
	assign sts.pend_vld    = pend_vld_q;
	assign sts.slot_free   = slot_free;

	assign out_valid  = out_vld_q;
	assign common_key = out_key_q;
	assign found      = out_found_q;
	assign last       = out_last_q;
	assign overflow   = out_ovf_q;

endmodule

// ===== tb/sv/sid_result_checker.sv =====
// Checker for set_intersection_distinct: watches both channels, predicts
// the results of each accepted request and compares them in order.
// Depends on sid_pkg.
module sid_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [sid_pkg::OP_W-1:0]      operation,
	input  logic [sid_pkg::KEY_WIDTH-1:0] key,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [sid_pkg::KEY_WIDTH-1:0] common_key,
	input  logic                          found,
	input  logic                          last,
	input  logic                          overflow,
	output int                            mismatches,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import sid_pkg::*;

	typedef struct packed {
		logic [KEY_WIDTH-1:0] common_key;
		logic                 found;
		logic                 last;
		logic                 overflow;
	} common_result_t;

	logic [KEY_WIDTH-1:0] first_keys [DEPTH];
	logic [KEY_WIDTH-1:0] second_keys [DEPTH];
	int                   first_count;
	int                   second_count;
	logic                 overflow_seen;
	common_result_t       expected_results [$];
	int                   error_count;

	initial begin
		error_count = 0;
	end

	function automatic logic in_first(input int n, input logic [KEY_WIDTH-1:0] k);
		for (int j = 0; j < n; j++)
			if (first_keys[j] == k)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic in_second(input logic [KEY_WIDTH-1:0] k);
		for (int j = 0; j < second_count; j++)
			if (second_keys[j] == k)
				return 1'b1;
		return 1'b0;
	endfunction

	task automatic predict_request(input logic [OP_W-1:0] op, input logic [KEY_WIDTH-1:0] k);
		logic [KEY_WIDTH-1:0] hits [$];
		common_result_t       r;
		case (op)
			OP_ADD_FIRST: begin
				if (first_count >= DEPTH) begin
					overflow_seen = 1'b1;
				end else begin
					first_keys[first_count] = k;
					first_count++;
				end
			end
			OP_ADD_SECOND: begin
				if (second_count >= DEPTH) begin
					overflow_seen = 1'b1;
				end else begin
					second_keys[second_count] = k;
					second_count++;
				end
			end
			OP_RUN: begin
				for (int i = 0; i < first_count; i++)
					if (!in_first(i, first_keys[i]) && in_second(first_keys[i]))
						hits = {hits, first_keys[i]};
				if (hits.size() == 0) begin
					r = '{common_key: '0, found: 1'b0, last: 1'b1, overflow: overflow_seen};
					expected_results = {expected_results, r};
				end
				for (int i = 0; i < hits.size(); i++) begin
					r = '{common_key: hits[i], found: 1'b1, last: (i == hits.size() - 1),
						overflow: overflow_seen};
					expected_results = {expected_results, r};
				end
				first_count   = 0;
				second_count  = 0;
				overflow_seen = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic compare_result();
		common_result_t e;
		if (expected_results.size() == 0) begin
			$error("unexpected result: common_key %h found %b last %b overflow %b",
				common_key, found, last, overflow);
			error_count++;
			return;
		end
		e = expected_results.pop_front();
		if (common_key !== e.common_key) begin
			$error("common_key: expected %h, actual %h", e.common_key, common_key);
			error_count++;
		end
		if (found !== e.found) begin
			$error("found: expected %b, actual %b", e.found, found);
			error_count++;
		end
		if (last !== e.last) begin
			$error("last: expected %b, actual %b", e.last, last);
			error_count++;
		end
		if (overflow !== e.overflow) begin
			$error("overflow: expected %b, actual %b", e.overflow, overflow);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			first_count   = 0;
			second_count  = 0;
			overflow_seen = 1'b0;
		end else begin
			if (in_valid && !in_stall)
				predict_request(operation, key);
			if (out_valid && !out_stall)
				compare_result();
		end
		mismatches  <= error_count;
		outstanding <= expected_results.size();
	end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the set_intersection_distinct testbench: clock, reset, request
// stimulus, output stalls, watchdog and verdict.
// Depends on sid_pkg, set_intersection_distinct and sid_result_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sid_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 410;
	localparam int QUIET_LIMIT     = 20000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 out_stall = 1'b0;
	logic [OP_W-1:0]      operation = '0;
	logic [KEY_WIDTH-1:0] key       = '0;
	logic                 in_stall;
	logic                 out_valid;
	logic [KEY_WIDTH-1:0] common_key;
	logic                 found;
	logic                 last;
	logic                 overflow;
	int                   mismatches;
	int                   outstanding;
	int                   idle_pct     = 0;
	int                   stall_pct    = 0;
	int                   sent         = 0;
	int                   quiet_cycles = 0;
	logic [KEY_WIDTH-1:0] key_pool [8];

	set_intersection_distinct i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.key       (key),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.common_key(common_key),
		.found     (found),
		.last      (last),
		.overflow  (overflow)
	);

	sid_result_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.key        (key),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.common_key (common_key),
		.found      (found),
		.last       (last),
		.overflow   (overflow),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_WIDTH-1:0] k);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			key      <= {$urandom, $urandom};
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		key       <= k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (op != OP_UNUSED)
			sent++;
	endtask

	// hold off until every expected result has arrived
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	function automatic logic [KEY_WIDTH-1:0] pick_key();
		if ($urandom_range(99) < 60)
			return key_pool[$urandom_range(7)];
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_count();
		if ($urandom_range(99) < 12)
			return $urandom_range(34, 28);
		return $urandom_range(6, 0);
	endfunction

	task automatic load_and_run(input int n1, input int n2);
		int left1;
		int left2;
		left1 = n1;
		left2 = n2;
		for (int i = 0; i < 8; i++)
			key_pool[i] = {$urandom, $urandom};
		while (left1 + left2 > 0) begin
			if ($urandom_range(19) == 0)
				send_request(OP_UNUSED, {$urandom, $urandom});
			if (left2 == 0 || (left1 > 0 && $urandom_range(1) == 0)) begin
				send_request(OP_ADD_FIRST, pick_key());
				left1--;
			end else begin
				send_request(OP_ADD_SECOND, pick_key());
				left2--;
			end
		end
		send_request(OP_RUN, {$urandom, $urandom});
	endtask

	initial begin
		int seq;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_RUN, '1);
		send_request(OP_UNUSED, '1);
		send_request(OP_ADD_FIRST, '0);
		send_request(OP_ADD_FIRST, '1);
		send_request(OP_ADD_FIRST, '0);
		send_request(OP_ADD_FIRST, 64'h5);
		send_request(OP_ADD_SECOND, '1);
		send_request(OP_ADD_SECOND, 64'h7);
		send_request(OP_ADD_SECOND, '0);
		send_request(OP_ADD_SECOND, '1);
		send_request(OP_RUN, '0);
		send_request(OP_ADD_FIRST, 64'h8000_0000_0000_0000);
		send_request(OP_ADD_FIRST, 64'h1);
		send_request(OP_ADD_SECOND, 64'h7fff_ffff_ffff_ffff);
		send_request(OP_ADD_SECOND, 64'h2);
		send_request(OP_RUN, '1);
		wait_drained();

		sent = 0;
		seq  = 0;
		while (sent < RANDOM_REQUESTS) begin
			case ((seq / 6) % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 51; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 51; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase
			if ($urandom_range(7) == 0)
				load_and_run(0, pick_count());
			else
				load_and_run(pick_count(), pick_count());
			if (seq == 9)
				wait_drained();
			seq++;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sid_pkg.sv
rtl/sid_ctrl.sv
rtl/sid_dp.sv
rtl/set_intersection_distinct.sv
tb/sv/sid_result_checker.sv
tb/sv/tb.sv
